// ===== src/tcgw_pkg.sv =====
// Shared types and constants for the text console glyph writer.
// No dependencies; used by every module of the block.
package tcgw_pkg;

	// Glyph geometry and font size
	localparam int GlyphWidth   = 8;
	localparam int GlyphHeight  = 16;
	localparam int FontChars    = 256;
	localparam int FontStride   = 16;
	localparam int FontDepth    = 4096;
	localparam int FontAddrW    = 12;
	localparam int RowW         = (GlyphHeight > 1) ? $clog2(GlyphHeight) : 1;
	localparam int LineW        = 8 + RowW;
	localparam int ProdW        = 16 + LineW;
	localparam int BytesPerPix  = 4;

	// Command queue between front and back
	localparam int QDepth = 4;
	localparam int QPtrW  = 2;
	localparam int QCntW  = 3;

	// Opcodes
	localparam logic OpChar = 1'b0;
	localparam logic OpFont = 1'b1;

	// Control characters
	localparam logic [7:0] ChNul = 8'h00;
	localparam logic [7:0] ChTab = 8'h09;
	localparam logic [7:0] ChLf  = 8'h0a;
	localparam logic [7:0] ChCr  = 8'h0d;
	localparam logic [7:0] TabMask = 8'd3;

	// Configuration register indexes
	localparam logic [2:0] RegColumns = 3'd0;
	localparam logic [2:0] RegRows    = 3'd1;
	localparam logic [2:0] RegPitch   = 3'd2;
	localparam logic [2:0] RegBase    = 3'd3;
	localparam logic [2:0] RegFore    = 3'd4;
	localparam logic [2:0] RegBack    = 3'd5;

	typedef struct packed {
		logic [8:0]  text_columns;
		logic [8:0]  text_rows;
		logic [15:0] line_pitch;
		logic [31:0] frame_base;
		logic [31:0] fore_color;
		logic [31:0] back_color;
	} cfg_t;

	// One queued command: a font byte load or a glyph to draw
	typedef struct packed {
		logic                 op_font;
		logic [7:0]           char_code;
		logic [7:0]           col;
		logic [7:0]           row;
		logic [FontAddrW-1:0] font_index;
		logic [7:0]           font_byte;
	} qent_t;

endpackage

// ===== src/tcgw_front.sv =====
// Front end: accepts input beats, keeps the text cursor, queues draws and font loads.
// Depends on tcgw_pkg.
module tcgw_front
	import tcgw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 opcode,
	input  logic [7:0]           char_code,
	input  logic [FontAddrW-1:0] font_index,
	input  logic [7:0]           font_byte,
	input  logic                 q_full,
	output logic                 q_push,
	output qent_t                q_din
);

	logic [7:0] cur_col_q, cur_row_q;
	logic       accept, drawable;
	logic [8:0] col_n, cols;
	logic [9:0] row_n, rows;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Classify the byte
	always_comb begin
		drawable = 1'b0;
		case (char_code)
			ChNul, ChTab, ChLf, ChCr: drawable = 1'b0;
			default:                  drawable = 1'b1;
		endcase
	end

	// Next cursor position, wrapped against the clamped screen size
	always_comb begin
		cols  = (cfg.text_columns > 9'd256) ? 9'd256 : cfg.text_columns;
		rows  = (cfg.text_rows > 9'd256) ? 10'd256 : {1'b0, cfg.text_rows};
		col_n = {1'b0, cur_col_q};
		row_n = {2'b0, cur_row_q};
		case (char_code)
			ChNul: ;
			ChTab: col_n = {1'b0, cur_col_q | TabMask} + 9'd1;
			ChLf: begin
				col_n = 9'd0;
				row_n = row_n + 10'd1;
			end
			ChCr:    col_n = 9'd0;
			default: col_n = col_n + 9'd1;
		endcase
		if (col_n >= cols) begin
			col_n = 9'd0;
			row_n = row_n + 10'd1;
		end
		if (row_n >= rows) begin
			row_n = 10'd0;
		end
	end

	// Cursor registers; font loads leave it alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= 8'd0;
			cur_row_q <= 8'd0;
		end else if (accept && opcode == OpChar) begin
			cur_col_q <= col_n[7:0];
			cur_row_q <= row_n[7:0];
		end
	end

	// Queue font loads and drawable bytes with the cursor before the move
	assign q_push = accept && (opcode == OpFont || drawable);
	always_comb begin
		q_din.op_font    = opcode;
		q_din.char_code  = char_code;
		q_din.col        = cur_col_q;
		q_din.row        = cur_row_q;
		q_din.font_index = font_index;
		q_din.font_byte  = font_byte;
	end

endmodule

// ===== src/tcgw_queue.sv =====
// Short command queue between the front end and the glyph engine.
// Depends on tcgw_pkg.
module tcgw_queue
	import tcgw_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t din,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output qent_t head
);

	qent_t            mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0] count_q;

	assign full       = (count_q == QCntW'(QDepth));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= din;
	end

endmodule

// ===== src/tcgw_back.sv =====
// Glyph engine: font memory, row sequencer and two-stage pixel pipeline.
// Depends on tcgw_pkg; fed by tcgw_queue.
module tcgw_back
	import tcgw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        head_valid,
	input  qent_t       head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] row_address,
	output logic [31:0] pixel_a,
	output logic [31:0] pixel_b,
	output logic [31:0] pixel_c,
	output logic [31:0] pixel_d,
	output logic [31:0] pixel_e,
	output logic [31:0] pixel_f,
	output logic [31:0] pixel_g,
	output logic [31:0] pixel_h,
	output logic        last_row
);

	localparam logic [31:0] ColBytes = 32'(GlyphWidth * BytesPerPix);

	logic [7:0]           font_mem [FontDepth];
	logic [RowW-1:0]      r_q;
	logic                 stall, adv, issue, font_wr, r_last;
	logic [FontAddrW-1:0] raddr;
	logic [LineW-1:0]     line;

	logic                 s1_valid_q;
	logic [7:0]           fdata_s1;
	logic                 infont_s1;
	logic [ProdW-1:0]     prod_s1;
	logic [7:0]           col_s1;
	logic                 last_s1;
	logic [7:0]           bits;

	// Global stall from the output register
	assign stall   = out_valid && !out_ready;
	assign adv     = !stall;
	assign issue   = adv && head_valid && head.op_font == OpChar;
	assign font_wr = adv && head_valid && head.op_font == OpFont;
	assign r_last  = (r_q == RowW'(GlyphHeight - 1));
	assign pop     = font_wr || (issue && r_last);

	assign raddr = FontAddrW'(FontAddrW'(head.char_code) * FontAddrW'(FontStride)
		+ FontAddrW'(r_q));
	assign line  = LineW'(LineW'(head.row) * LineW'(GlyphHeight) + LineW'(r_q));

	// Row sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
		end else if (issue) begin
			r_q <= r_last ? '0 : r_q + 1'b1;
		end
	end

	// Font memory: loads and glyph row reads happen in queue order
	always_ff @(posedge clk) begin
		if (font_wr) font_mem[head.font_index] <= head.font_byte;
		if (issue)   fdata_s1 <= font_mem[raddr];
	end

	// Stage 1: font row read and pitch product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			infont_s1 <= ({1'b0, head.char_code} < 9'(FontChars));
			prod_s1   <= ProdW'(cfg.line_pitch) * ProdW'(line);
			col_s1    <= head.col;
			last_s1   <= r_last;
		end
	end

	// Stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= s1_valid_q;
		end
	end

	assign bits = infont_s1 ? fdata_s1 : 8'd0;

	always_ff @(posedge clk) begin
		if (adv && s1_valid_q) begin
			row_address <= cfg.frame_base + 32'(prod_s1) + 32'(col_s1) * ColBytes;
			pixel_a     <= bits[7] ? cfg.fore_color : cfg.back_color;
			pixel_b     <= bits[6] ? cfg.fore_color : cfg.back_color;
			pixel_c     <= bits[5] ? cfg.fore_color : cfg.back_color;
			pixel_d     <= bits[4] ? cfg.fore_color : cfg.back_color;
			pixel_e     <= bits[3] ? cfg.fore_color : cfg.back_color;
			pixel_f     <= bits[2] ? cfg.fore_color : cfg.back_color;
			pixel_g     <= bits[1] ? cfg.fore_color : cfg.back_color;
			pixel_h     <= bits[0] ? cfg.fore_color : cfg.back_color;
			last_row    <= last_s1;
		end
	end

`ifndef SYNTHESIS
	// Row counter freezes while the output is stalled
	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> $stable(r_q))
		else $error("row counter moved during stall");

	// Mid-glyph the queue head must be the glyph being drawn
	a_mid_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		(r_q != '0) |-> (head_valid && head.op_font == OpChar))
		else $error("row counter busy without a draw at queue head");

	// Last glyph row reaches the output with its flag
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && last_s1 && adv) |=> (out_valid && last_row))
		else $error("last row flag lost");
`endif

endmodule

// ===== src/text_console_glyph_writer.sv =====
// Top level of the text console glyph writer: configuration registers and wiring.
// Depends on tcgw_pkg, tcgw_front, tcgw_queue, tcgw_back.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  input   | in_valid / in_ready    | opcode, char_code, font_index, font_byte
//  output  | out_valid / out_ready  | row_address, pixel_a..pixel_h, last_row
//  config  | cfg_we                 | cfg_index, cfg_data
//
// A drawn character gives 16 row beats, one per cycle while out_ready is high; the glyph
// engine's row sequencer starts the next character only after the last row of this one issues.
// Control bytes never enter the queue.
// The first row beat passes through the queue, stage 1 and the output register.
// A four-entry queue lets input beats be taken while the engine draws or stalls.
// Reset clears the cursor and config registers; font memory is not cleared.
module text_console_glyph_writer
	import tcgw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 opcode,
	input  logic [7:0]           char_code,
	input  logic [FontAddrW-1:0] font_index,
	input  logic [7:0]           font_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          row_address,
	output logic [31:0]          pixel_a,
	output logic [31:0]          pixel_b,
	output logic [31:0]          pixel_c,
	output logic [31:0]          pixel_d,
	output logic [31:0]          pixel_e,
	output logic [31:0]          pixel_f,
	output logic [31:0]          pixel_g,
	output logic [31:0]          pixel_h,
	output logic                 last_row
);

	cfg_t  cfg_q;
	logic  q_full, q_push, q_pop, q_head_valid;
	qent_t q_din, q_head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_columns <= 9'd80;
			cfg_q.text_rows    <= 9'd25;
			cfg_q.line_pitch   <= 16'd2560;
			cfg_q.frame_base   <= 32'd0;
			cfg_q.fore_color   <= 32'h00ff_ffff;
			cfg_q.back_color   <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				RegColumns: cfg_q.text_columns <= cfg_data[8:0];
				RegRows:    cfg_q.text_rows    <= cfg_data[8:0];
				RegPitch:   cfg_q.line_pitch   <= cfg_data[15:0];
				RegBase:    cfg_q.frame_base   <= cfg_data;
				RegFore:    cfg_q.fore_color   <= cfg_data;
				RegBack:    cfg_q.back_color   <= cfg_data;
				default:    ;
			endcase
		end
	end

	tcgw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.char_code  (char_code),
		.font_index (font_index),
		.font_byte  (font_byte),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_din      (q_din)
	);

	tcgw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.din        (q_din),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	tcgw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head_valid  (q_head_valid),
		.head        (q_head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.row_address (row_address),
		.pixel_a     (pixel_a),
		.pixel_b     (pixel_b),
		.pixel_c     (pixel_c),
		.pixel_d     (pixel_d),
		.pixel_e     (pixel_e),
		.pixel_f     (pixel_f),
		.pixel_g     (pixel_g),
		.pixel_h     (pixel_h),
		.last_row    (last_row)
	);

endmodule

// ===== sim/glyph_row_checker.sv =====
`timescale 1ns / 1ps
// Checker for the text console glyph writer: predicts glyph row beats and compares them.
// Depends on tcgw_pkg; watches the config port and both channels of the block.
module glyph_row_checker
	import tcgw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic                 opcode,
	input  logic [7:0]           char_code,
	input  logic [FontAddrW-1:0] font_index,
	input  logic [7:0]           font_byte,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [31:0]          row_address,
	input  logic [31:0]          pixel_a,
	input  logic [31:0]          pixel_b,
	input  logic [31:0]          pixel_c,
	input  logic [31:0]          pixel_d,
	input  logic [31:0]          pixel_e,
	input  logic [31:0]          pixel_f,
	input  logic [31:0]          pixel_g,
	input  logic [31:0]          pixel_h,
	input  logic                 last_row,
	output int                   rows_due,
	output int                   mismatches
);

	localparam int TabStop   = 4;
	localparam int MaxScreen = 256;

	// One glyph row beat; pix[0] is the leftmost pixel
	typedef struct packed {
		logic [31:0]      row_address;
		logic [7:0][31:0] pix;
		logic             last_row;
	} glyph_row_t;

	cfg_t        setup;
	logic [7:0]  cur_col;
	logic [7:0]  cur_row;
	logic [7:0]  font_mem [FontDepth];
	glyph_row_t  pending_rows [$];
	int          fail_count = 0;

	assign mismatches = fail_count;

	task automatic flag_mismatch(input string what);
		fail_count++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	function automatic int unsigned clamp_dim(input logic [8:0] v);
		return (v > MaxScreen) ? MaxScreen : int'(v);
	endfunction

	// Cursor update for one character byte; drawable bytes queue 16 row beats
	task automatic take_char(input logic [7:0] code);
		int unsigned col;
		int unsigned row;
		int unsigned line;
		logic [7:0]  bits;
		glyph_row_t  beat;
		col = cur_col;
		row = cur_row;
		case (code)
			ChNul: ;
			ChTab: col = col + TabStop - (col % TabStop);
			ChLf: begin
				col = 0;
				row++;
			end
			ChCr: col = 0;
			default: begin
				for (int r = 0; r < GlyphHeight; r++) begin
					bits = (int'(code) < FontChars) ? font_mem[int'(code) * FontStride + r] : '0;
					line = row * GlyphHeight + r;
					beat.row_address = setup.frame_base + setup.line_pitch * line
						+ col * GlyphWidth * BytesPerPix;
					for (int x = 0; x < GlyphWidth; x++) begin
						beat.pix[x] = bits[GlyphWidth-1-x] ? setup.fore_color : setup.back_color;
					end
					beat.last_row = (r == GlyphHeight - 1);
					pending_rows.push_back(beat);
				end
				col++;
			end
		endcase
		// wrap after every character byte
		if (col >= clamp_dim(setup.text_columns)) begin
			col = 0;
			row++;
		end
		if (row >= clamp_dim(setup.text_rows)) begin
			row = 0;
		end
		cur_col = 8'(col);
		cur_row = 8'(row);
	endtask

	task automatic check_row();
		glyph_row_t got;
		glyph_row_t want;
		got.row_address = row_address;
		got.pix = {pixel_h, pixel_g, pixel_f, pixel_e, pixel_d, pixel_c, pixel_b, pixel_a};
		got.last_row = last_row;
		if (pending_rows.size() == 0) begin
			flag_mismatch($sformatf("row beat with nothing expected, address %h", row_address));
			return;
		end
		want = pending_rows.pop_front();
		if (got.row_address !== want.row_address) begin
			flag_mismatch($sformatf("row_address %h, expected %h",
				got.row_address, want.row_address));
		end
		for (int x = 0; x < GlyphWidth; x++) begin
			if (got.pix[x] !== want.pix[x]) begin
				flag_mismatch($sformatf("pixel %0d at %h is %h, expected %h",
					x, want.row_address, got.pix[x], want.pix[x]));
			end
		end
		if (got.last_row !== want.last_row) begin
			flag_mismatch($sformatf("last_row %b at %h, expected %b",
				got.last_row, want.row_address, want.last_row));
		end
	endtask

	// Register mirror, font copy and cursor follow the accepted beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup.text_columns = 9'd80;
			setup.text_rows    = 9'd25;
			setup.line_pitch   = 16'd2560;
			setup.frame_base   = 32'h0000_0000;
			setup.fore_color   = 32'h00FF_FFFF;
			setup.back_color   = 32'h0000_0000;
			cur_col = '0;
			cur_row = '0;
			pending_rows.delete();
			rows_due <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					RegColumns: setup.text_columns = cfg_data[8:0];
					RegRows:    setup.text_rows    = cfg_data[8:0];
					RegPitch:   setup.line_pitch   = cfg_data[15:0];
					RegBase:    setup.frame_base   = cfg_data;
					RegFore:    setup.fore_color   = cfg_data;
					RegBack:    setup.back_color   = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				check_row();
			end
			if (in_valid && in_ready) begin
				if (opcode == OpFont) begin
					font_mem[font_index] = font_byte;
				end else begin
					take_char(char_code);
				end
			end
			rows_due <= pending_rows.size();
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the glyph writer testbench: clock, reset, stimulus, config phases and verdict.
// Depends on tcgw_pkg, text_console_glyph_writer and glyph_row_checker.
module tb_top;
	import tcgw_pkg::*;

	localparam int          StallLimit = 4000;
	localparam int          SettleWait = 24;
	localparam logic [7:0]  FullGlyph  = 8'hFF;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [2:0]           cfg_index = '0;
	logic [31:0]          cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 opcode = OpChar;
	logic [7:0]           char_code = '0;
	logic [FontAddrW-1:0] font_index = '0;
	logic [7:0]           font_byte = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [31:0]          row_address;
	logic [31:0]          pixel_a, pixel_b, pixel_c, pixel_d;
	logic [31:0]          pixel_e, pixel_f, pixel_g, pixel_h;
	logic                 last_row;
	int                   rows_due;
	int                   mismatches;

	int unsigned          items_sent = 0;
	int unsigned          quiet_cycles = 0;
	bit                   send_gaps = 1'b1;
	bit                   recv_stalls = 1'b1;
	logic [FontDepth-1:0] font_loaded = '0;
	bit                   listed [FontChars];
	logic [7:0]           ready_glyphs [$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_console_glyph_writer i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .char_code(char_code), .font_index(font_index), .font_byte(font_byte),
		.out_valid(out_valid), .out_ready(out_ready), .row_address(row_address),
		.pixel_a(pixel_a), .pixel_b(pixel_b), .pixel_c(pixel_c), .pixel_d(pixel_d),
		.pixel_e(pixel_e), .pixel_f(pixel_f), .pixel_g(pixel_g), .pixel_h(pixel_h),
		.last_row(last_row)
	);

	glyph_row_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .char_code(char_code), .font_index(font_index), .font_byte(font_byte),
		.out_valid(out_valid), .out_ready(out_ready), .row_address(row_address),
		.pixel_a(pixel_a), .pixel_b(pixel_b), .pixel_c(pixel_c), .pixel_d(pixel_d),
		.pixel_e(pixel_e), .pixel_f(pixel_f), .pixel_g(pixel_g), .pixel_h(pixel_h),
		.last_row(last_row), .rows_due(rows_due), .mismatches(mismatches)
	);

	// Watchdog: too long without any accepted beat ends the run
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= StallLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver: ready stays high for random stretches, broken by stall bursts
	initial begin
		forever begin
			if (recv_stalls && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	function automatic bit is_control(input logic [7:0] c);
		return c == ChNul || c == ChTab || c == ChLf || c == ChCr;
	endfunction

	// One input beat; valid stays up after acceptance unless a gap follows
	task automatic send_beat(input logic op, input logic [7:0] ch,
			input logic [FontAddrW-1:0] idx, input logic [7:0] fb);
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		char_code  <= ch;
		font_index <= idx;
		font_byte  <= fb;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// Font load; a glyph becomes drawable once all of its rows are written
	task automatic put_font(input logic [FontAddrW-1:0] idx, input logic [7:0] fb);
		int unsigned c;
		send_beat(OpFont, 8'($urandom), idx, fb);
		font_loaded[idx] = 1'b1;
		c = idx / FontStride;
		if (!listed[c] && &font_loaded[c*FontStride +: FontStride] && !is_control(8'(c))) begin
			listed[c] = 1'b1;
			ready_glyphs.push_back(8'(c));
		end
	endtask

	task automatic put_char(input logic [7:0] c);
		send_beat(OpChar, c, FontAddrW'($urandom), 8'($urandom));
	endtask

	task automatic load_glyph(input logic [7:0] c);
		logic [7:0] bits;
		for (int r = 0; r < GlyphHeight; r++) begin
			case ($urandom_range(0, 3))
				0: bits = 8'h00;
				1: bits = 8'hFF;
				default: bits = 8'($urandom);
			endcase
			put_font(FontAddrW'(int'(c) * FontStride + r), bits);
		end
	endtask

	task automatic random_item();
		int unsigned dice;
		dice = $urandom_range(0, 99);
		if (dice < 12) begin
			load_glyph(8'($urandom));
		end else if (dice < 18) begin
			put_font(FontAddrW'($urandom), 8'($urandom));
		end else if (dice < 36) begin
			case ($urandom_range(0, 3))
				0: put_char(ChNul);
				1: put_char(ChTab);
				2: put_char(ChLf);
				default: put_char(ChCr);
			endcase
		end else if (ready_glyphs.size() == 0) begin
			load_glyph(8'($urandom));
		end else begin
			put_char(ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)]);
		end
	endtask

	task automatic run_items(input int unsigned count);
		int unsigned target;
		target = items_sent + count;
		while (items_sent < target) random_item();
	endtask

	// Hold the sender until every expected row beat is out, then let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (rows_due != 0) @(posedge clk);
		repeat (SettleWait) @(posedge clk);
	endtask

	task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [8:0] cols, input logic [8:0] rows,
			input logic [15:0] pitch, input logic [31:0] base,
			input logic [31:0] fore, input logic [31:0] back);
		// unused upper bits carry noise
		set_reg(RegColumns, {23'($urandom), cols});
		set_reg(RegRows, {23'($urandom), rows});
		set_reg(RegPitch, {16'($urandom), pitch});
		set_reg(RegBase, base);
		set_reg(RegFore, fore);
		set_reg(RegBack, back);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: font index extremes, a glyph with edge bit patterns, every control byte
		put_font('0, 8'h00);
		put_font(FontAddrW'(int'(FullGlyph) * FontStride + 0), 8'h80);
		put_font(FontAddrW'(int'(FullGlyph) * FontStride + 1), 8'h01);
		put_font(FontAddrW'(int'(FullGlyph) * FontStride + 2), 8'hFF);
		put_font(FontAddrW'(int'(FullGlyph) * FontStride + 3), 8'h00);
		for (int r = 4; r < GlyphHeight; r++) begin
			put_font(FontAddrW'(int'(FullGlyph) * FontStride + r), 8'($urandom));
		end
		put_char(FullGlyph);
		put_char(ChNul);
		put_char(ChTab);
		put_char(FullGlyph);
		put_char(ChCr);
		put_char(ChLf);
		put_char(FullGlyph);
		run_items(50);
		wait_idle();

		// Tiny screen, address wraps past 2^32; cursor may start off screen
		program_regs(9'd4, 9'd3, 16'hFFFF, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
		run_items(60);
		wait_idle();

		// Oversized width acts as 256, single row, no idling in this phase
		send_gaps = 1'b0;
		recv_stalls = 1'b0;
		program_regs(9'h1FF, 9'd1, 16'd0, 32'h0, 32'h0, 32'hFFFF_FFFF);
		run_items(50);
		wait_idle();

		// Zero geometry
		send_gaps = 1'b1;
		recv_stalls = 1'b1;
		program_regs(9'd0, 9'd0, 16'($urandom), $urandom, $urandom, $urandom);
		run_items(40);
		wait_idle();

		// One column, full height
		program_regs(9'd1, 9'd256, 16'($urandom), $urandom, $urandom, $urandom);
		run_items(40);
		wait_idle();

		// Small random screen
		program_regs(9'($urandom_range(1, 12)), 9'($urandom_range(1, 6)),
			16'($urandom), $urandom, $urandom, $urandom);
		run_items(50);
		wait_idle();

		// Closing stretch at full rate on both sides
		send_gaps = 1'b0;
		recv_stalls = 1'b0;
		program_regs(9'($urandom_range(1, 40)), 9'($urandom_range(1, 30)),
			16'($urandom), $urandom, $urandom, $urandom);
		run_items(50);
		wait_idle();

		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
